// File: rtl/hmdc_pkg.sv
// Shared types and constants for the heater mode and duty controller.
// Used by the controller, the datapath and the top level; depends on nothing.
package hmdc_pkg;

  // Duty scale: 1600 is 100 %, in steps of 1/16 %.
  localparam logic [10:0] DUTY_FULL       = 11'd1600;
  localparam logic [10:0] DUTY_BASE       = 11'd80;
  localparam logic [15:0] FAIL_LIMIT      = 16'd5;
  localparam logic [15:0] SAT16           = 16'hFFFF;
  localparam logic [15:0] TIMER_TOP_RESET = 16'd999;

  // Error of 5 C or more below target selects full power (1/16 C units).
  localparam logic signed [12:0] AUTO_FULL_ERR = 13'sd80;

  // ceil(2^26 / 25): exact floor division by 25 for dividends below 2^21.
  localparam logic [21:0] RECIP_25 = 22'd2684355;
  localparam int unsigned RECIP_SHIFT = 26;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CONTROL_MODE   = 3'd0;
  localparam logic [2:0] CFG_MANUAL_DUTY    = 3'd1;
  localparam logic [2:0] CFG_ENV_THRESHOLD  = 3'd2;
  localparam logic [2:0] CFG_SURFACE_TARGET = 3'd3;
  localparam logic [2:0] CFG_ALARM_ENABLE   = 3'd4;
  localparam logic [2:0] CFG_TIMER_TOP      = 3'd5;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_FULL   = 2'd1,
    MODE_MANUAL = 2'd2,
    MODE_AUTO   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_DUTY  = 2'd1,
    S_SCALE = 2'd2,
    S_LOAD  = 2'd3
  } state_t;

  // Per-probe health and history.
  typedef struct packed {
    logic [11:0] temp;
    logic [15:0] streak;
    logic        faulty;
    logic [15:0] total;
  } probe_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic probe_en;
    logic duty_en;
    logic scale_en;
    logic load_en;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/hmdc_ctrl.sv
// Controller state machine for the heater mode and duty controller.
// Sequences one transaction through the datapath; depends on hmdc_pkg.
module hmdc_ctrl
  import hmdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output ctrl_cmd_t cmd,
  input  dp_stat_t  stat
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DUTY;
      end
      S_DUTY:  state_next = S_SCALE;
      S_SCALE: state_next = S_LOAD;
      S_LOAD: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state)
      S_IDLE: begin
        in_stall     = 1'b0;
        cmd.probe_en = in_valid;
      end
      S_DUTY:  cmd.duty_en  = 1'b1;
      S_SCALE: cmd.scale_en = 1'b1;
      S_LOAD:  cmd.load_en  = stat.out_free;
      default: in_stall = 1'b1;
    endcase
  end

endmodule

// File: rtl/hmdc_dp.sv
// Datapath for the heater mode and duty controller: configuration registers,
// probe history, duty selection, PWM scaling and the output register. Uses hmdc_pkg.
module hmdc_dp
  import hmdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        env_read_ok,
  input  logic [11:0] env_reading,
  input  logic        surf_read_ok,
  input  logic [11:0] surf_reading,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [15:0] pwm_compare,
  output logic [10:0] duty_out,
  output logic [13:0] heat_volt_mv,
  output logic [11:0] status_word,
  output logic [6:0]  fault_word,
  output logic [15:0] env_err_count,
  output logic [15:0] surf_err_count
);

  // Probe history update for one read.
  function automatic probe_state_t probe_next(probe_state_t cur, logic ok,
                                             logic [11:0] reading);
    probe_state_t nxt;
    nxt = cur;
    if (ok) begin
      nxt.temp   = reading;
      nxt.streak = '0;
      nxt.faulty = 1'b0;
    end else begin
      if (cur.total != SAT16) nxt.total = cur.total + 16'd1;
      if (cur.streak != SAT16) nxt.streak = cur.streak + 16'd1;
      if (nxt.streak >= FAIL_LIMIT) nxt.faulty = 1'b1;
    end
    return nxt;
  endfunction

  mode_t              control_mode;
  logic [10:0]        manual_duty;
  logic signed [11:0] env_threshold;
  logic signed [11:0] surface_target;
  logic               alarm_enable;
  logic [15:0]        timer_top;

  probe_state_t env_probe;
  probe_state_t surf_probe;

  logic [10:0] duty_r;
  logic [11:0] status_r;
  logic [6:0]  fault_r;
  logic [26:0] prod_r;

  logic               probes_ok;
  logic signed [12:0] temp_err;
  logic [6:0]         err_small;
  logic [10:0]        duty_next;
  logic               full_stage;
  logic               reg_stage;
  logic               out_enable;
  logic [27:0]        prod_full;
  logic [42:0]        quot_full;
  logic [15:0]        quot;
  logic [15:0]        compare_next;
  logic [14:0]        volt_full;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      control_mode   <= MODE_OFF;
      manual_duty    <= '0;
      env_threshold  <= '0;
      surface_target <= '0;
      alarm_enable   <= 1'b0;
      timer_top      <= TIMER_TOP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CONTROL_MODE:   control_mode   <= mode_t'(cfg_data[1:0]);
        CFG_MANUAL_DUTY:    manual_duty    <= cfg_data[10:0];
        CFG_ENV_THRESHOLD:  env_threshold  <= cfg_data[11:0];
        CFG_SURFACE_TARGET: surface_target <= cfg_data[11:0];
        CFG_ALARM_ENABLE:   alarm_enable   <= cfg_data[0];
        CFG_TIMER_TOP:      timer_top      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Probe history is updated in the cycle that accepts the transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      env_probe  <= '0;
      surf_probe <= '0;
    end else if (cmd.probe_en) begin
      env_probe  <= probe_next(env_probe, env_read_ok, env_reading);
      surf_probe <= probe_next(surf_probe, surf_read_ok, surf_reading);
    end
  end

  // Duty selection by control mode.
  assign probes_ok = !env_probe.faulty && !surf_probe.faulty;
  assign temp_err  = 13'(surface_target) - 13'($signed(surf_probe.temp));
  assign err_small = temp_err[6:0];

  always_comb begin
    duty_next  = '0;
    full_stage = 1'b0;
    reg_stage  = 1'b0;
    out_enable = 1'b0;
    unique case (control_mode)
      MODE_OFF: duty_next = '0;
      MODE_FULL: begin
        duty_next  = DUTY_FULL;
        out_enable = 1'b1;
      end
      MODE_MANUAL: begin
        duty_next  = (manual_duty > DUTY_FULL) ? DUTY_FULL : manual_duty;
        out_enable = (duty_next != '0);
      end
      MODE_AUTO: begin
        if (probes_ok && ($signed(env_probe.temp) < env_threshold)) begin
          if (temp_err >= AUTO_FULL_ERR) begin
            duty_next  = DUTY_FULL;
            full_stage = 1'b1;
            out_enable = 1'b1;
          end else if (temp_err > 13'sd0) begin
            // Error is 1 to 79 here, so 80 + 15*e stays below full scale.
            duty_next  = DUTY_BASE + ({err_small, 4'b0000} - {4'b0000, err_small});
            reg_stage  = 1'b1;
            out_enable = 1'b1;
          end
        end
      end
      default: duty_next = '0;
    endcase
  end

  // Duty, status and fault words are held for the rest of the transaction.
  always_ff @(posedge clk) begin
    if (cmd.duty_en) begin
      duty_r   <= duty_next;
      status_r <= {out_enable, 1'b0, !surf_probe.faulty, !env_probe.faulty, probes_ok,
                   1'b1, (duty_next != '0), reg_stage, full_stage,
                   (control_mode == MODE_MANUAL), (control_mode == MODE_AUTO), 1'b1};
      fault_r  <= alarm_enable ? {!probes_ok, 4'b0000, surf_probe.faulty, env_probe.faulty}
                               : 7'd0;
    end
  end

  // Duty times timer period; at most 1600 * 65536, so it fits in 27 bits.
  assign prod_full = 28'(duty_r) * 28'({1'b0, timer_top} + 17'd1);

  always_ff @(posedge clk) begin
    if (cmd.scale_en) begin
      prod_r <= prod_full[26:0];
    end
  end

  // Divide by 1600: drop six bits, then multiply by the reciprocal of 25.
  assign quot_full = 43'(prod_r[26:6]) * 43'(RECIP_25);
  assign quot      = quot_full[RECIP_SHIFT+15:RECIP_SHIFT];

  always_comb begin
    if (duty_r == '0) begin
      compare_next = '0;
    end else if (duty_r >= DUTY_FULL) begin
      compare_next = timer_top;
    end else begin
      compare_next = (quot > timer_top) ? timer_top : quot;
    end
  end

  // Output voltage estimate: duty * 15 / 2.
  assign volt_full = {duty_r, 4'b0000} - {4'b0000, duty_r};

  // Output register; a new result may load as the previous one is taken.
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      pwm_compare    <= compare_next;
      duty_out       <= duty_r;
      heat_volt_mv   <= volt_full[14:1];
      status_word    <= status_r;
      fault_word     <= fault_r;
      env_err_count  <= env_probe.total;
      surf_err_count <= surf_probe.total;
    end
  end

endmodule

// File: rtl/heater_mode_duty_control.sv
// Top level of the heater mode and duty controller.
// Joins hmdc_ctrl and hmdc_dp; depends on hmdc_pkg.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    env_read_ok, env_reading, surf_read_ok,
//                                               surf_reading
//   result    out        out_valid / out_stall  pwm_compare, duty_out, heat_volt_mv,
//                                               status_word, fault_word, env_err_count,
//                                               surf_err_count
//   config    in         cfg_write              cfg_index, cfg_data
//
// Each transaction runs through probe update at acceptance, duty selection,
// the duty by timer period multiply, then the divide by 1600 into the output register.
// The next transaction is accepted in the cycle after the result is loaded.
// Reset is synchronous and active high; it restores the register defaults and
// clears the probe history and the output valid flag.
// A held result does not block acceptance; a new result waits in the last step
// until the output register is free.
module heater_mode_duty_control
  import hmdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        env_read_ok,
  input  logic [11:0] env_reading,
  input  logic        surf_read_ok,
  input  logic [11:0] surf_reading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pwm_compare,
  output logic [10:0] duty_out,
  output logic [13:0] heat_volt_mv,
  output logic [11:0] status_word,
  output logic [6:0]  fault_word,
  output logic [15:0] env_err_count,
  output logic [15:0] surf_err_count
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Controller.
  hmdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Datapath.
  hmdc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .env_read_ok    (env_read_ok),
    .env_reading    (env_reading),
    .surf_read_ok   (surf_read_ok),
    .surf_reading   (surf_reading),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .pwm_compare    (pwm_compare),
    .duty_out       (duty_out),
    .heat_volt_mv   (heat_volt_mv),
    .status_word    (status_word),
    .fault_word     (fault_word),
    .env_err_count  (env_err_count),
    .surf_err_count (surf_err_count)
  );

`ifndef SYNTHESIS
  // An accepted transaction keeps the input side busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous transaction in progress");

  // A presented duty never exceeds full scale.
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_out <= DUTY_FULL))
    else $error("duty above full scale");

  // The heat status bit agrees with the presented duty.
  a_heat_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status_word[5] == (duty_out != 11'd0)))
    else $error("heat status bit disagrees with duty");

  // The voltage estimate agrees with the presented duty.
  a_volt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, heat_volt_mv} == (({duty_out, 4'b0000} - {4'b0000, duty_out}) >> 1)))
    else $error("voltage estimate disagrees with duty");
`endif

endmodule
